// ----- rtl/core/tlvs_pkg.sv -----
package tlvs_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;

    localparam int ID_W         = 16;
    localparam int LEN_W        = 16;
    localparam int LEFT_W       = 17;
    localparam int REGION_W     = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 24;

    localparam logic [ID_W-1:0]     ID_END        = 16'hffff;
    localparam logic [ID_W-1:0]     ID_NAME_TABLE = 16'h01ff;
    localparam logic [REGION_W-1:0] REGION_RESET  = 24'h010000;
    localparam logic [LEFT_W-1:0]   PAD_MASK      = ~17'h00003;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_ID   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_FIRST  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_SIZE = 2'd2;

    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_VALUE  = 4'b0010,
        PH_SKIP   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [ID_W-1:0]     target_id;
        logic                header_high_first;
        logic [REGION_W-1:0] region_size;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value_byte;
        logic       last;
        logic       truncated;
    } result_t;

endpackage

// ----- rtl/core/tlvs_ifs.sv -----
interface tlvs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, output data_byte, output first, input ready);
    modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface tlvs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value_byte;
    logic       last;
    logic       truncated;

    modport source (output valid, output kind, output value_byte, output last,
                    output truncated, input ready);
    modport sink   (input valid, input kind, input value_byte, input last,
                    input truncated, output ready);
endinterface

interface tlvs_cfg_if
    import tlvs_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/tlv_record_id_scanner.sv -----
// Channel      Modport  Payload                                  Request taken when
// byte_stream  sink     data_byte[7:0], first                    valid && ready
// result       source   kind[1:0], value_byte[7:0], last,        valid && ready
//                       truncated
// cfg          sink     index[1:0], data[23:0]                   valid && ready
//
// One byte per cycle while the result is not stalled: a byte taken into the input
// register fires into the walker, which updates its counters, and its result, if
// any, is registered in the result register when the byte fires.
// rst_n clears all control state; the walker then waits for a byte marked first.
// A stalled result holds both registers; the input side still takes a byte
// while the input register is empty.
module tlv_record_id_scanner
    import tlvs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    tlvs_in_if.sink    byte_stream,
    tlvs_out_if.source result,
    tlvs_cfg_if.sink   cfg
);

    cfg_t       cfg_val;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       res_valid_reg;
    result_t    res_reg;
    logic       advance;
    logic       fire;
    logic       step_valid;
    result_t    step_res;

    tlvs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    assign advance           = !res_valid_reg || result.ready;
    assign fire              = in_valid_reg && advance;
    assign byte_stream.ready = !in_valid_reg || advance;

    tlvs_walker #(
        .POSITION_BITS (POSITION_BITS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (in_byte_reg),
        .first     (in_first_reg),
        .cfg       (cfg_val),
        .res_valid (step_valid),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_stream.ready)
            begin
                in_valid_reg <= byte_stream.valid;
            end
            if (advance)
            begin
                res_valid_reg <= fire && step_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.ready && byte_stream.valid)
        begin
            in_byte_reg  <= byte_stream.data_byte;
            in_first_reg <= byte_stream.first;
        end
        if (fire && step_valid)
        begin
            res_reg <= step_res;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.kind       = res_reg.kind;
    assign result.value_byte = res_reg.value_byte;
    assign result.last       = res_reg.last;
    assign result.truncated  = res_reg.truncated;

endmodule

// ----- rtl/core/tlvs_cfg_regs.sv -----
module tlvs_cfg_regs
    import tlvs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    tlvs_cfg_if.sink       cfg,
    output cfg_t           cfg_out
);

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // Writes to an index beyond the register list are accepted and dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_id         <= ID_NAME_TABLE;
            cfg_reg.header_high_first <= 1'b0;
            cfg_reg.region_size       <= REGION_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TARGET_ID:   cfg_reg.target_id         <= cfg.data[ID_W-1:0];
                CFG_HIGH_FIRST:  cfg_reg.header_high_first <= cfg.data[0];
                CFG_REGION_SIZE: cfg_reg.region_size       <= cfg.data[REGION_W-1:0];
                default:         ;
            endcase
        end
    end

endmodule

// ----- rtl/core/tlvs_walker.sv -----
module tlvs_walker
    import tlvs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       first,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    localparam int CMP_W = (POSITION_BITS > REGION_W) ? POSITION_BITS : REGION_W;

    phase_t                   phase_reg, phase_next;
    logic [1:0]               hbc_reg, hbc_next;
    logic [ID_W-1:0]          id_reg, id_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEFT_W-1:0]        left_reg, left_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    phase_t                   ph;
    logic [1:0]               hbc;
    logic [ID_W-1:0]          id_cur;
    logic [LEN_W-1:0]         len_cur;
    logic [LEFT_W-1:0]        left_cur;
    logic [POSITION_BITS-1:0] pos_cur;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [LEFT_W-1:0]        left_dec;
    logic [LEFT_W-1:0]        padded;
    logic                     at_end;

    always_comb
    begin
        // A first byte restarts the walk before the byte itself is handled.
        if (first)
        begin
            ph       = PH_HEADER;
            hbc      = 2'd0;
            id_cur   = '0;
            len_cur  = '0;
            left_cur = '0;
            pos_cur  = '0;
        end
        else
        begin
            ph       = phase_reg;
            hbc      = hbc_reg;
            id_cur   = id_reg;
            len_cur  = len_reg;
            left_cur = left_reg;
            pos_cur  = pos_reg;
        end

        pos_inc  = (pos_cur != '1) ? pos_cur + 1'b1 : pos_cur;
        at_end   = CMP_W'(pos_inc) >= CMP_W'(cfg.region_size);
        left_dec = left_cur - 1'b1;

        phase_next = ph;
        hbc_next   = hbc;
        id_next    = id_cur;
        len_next   = len_cur;
        left_next  = left_cur;
        pos_next   = pos_cur;
        padded     = '0;
        res_valid  = 1'b0;
        res        = '{kind: KIND_NONE, value_byte: 8'd0, last: 1'b0, truncated: 1'b0};

        if (ph != PH_DONE)
        begin
            pos_next = pos_inc;
            case (ph)
                PH_VALUE:
                begin
                    left_next      = left_dec;
                    res_valid      = 1'b1;
                    res.kind       = KIND_VALUE;
                    res.value_byte = data_byte;
                    res.last       = (left_dec == '0) || at_end;
                    res.truncated  = (left_dec != '0) && at_end;
                    if (res.last)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    if (at_end)
                    begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else if (left_dec == '0)
                    begin
                        phase_next = PH_HEADER;
                        hbc_next   = 2'd0;
                    end
                end
                default:
                begin
                    if (!hbc[1])
                    begin
                        id_next = cfg.header_high_first ? {id_cur[7:0], data_byte}
                                                        : {data_byte, id_cur[15:8]};
                    end
                    else
                    begin
                        len_next = cfg.header_high_first ? {len_cur[7:0], data_byte}
                                                         : {data_byte, len_cur[15:8]};
                    end
                    hbc_next = hbc + 2'd1;
                    padded   = (LEFT_W'(len_next) + LEFT_W'(3)) & PAD_MASK;

                    if (hbc_next != 2'd0)
                    begin
                        if (at_end)
                        begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                    // The target compare comes first, so a target of the end
                    // marker id matches the end marker itself.
                    else if (id_next == cfg.target_id)
                    begin
                        if (len_next == '0 || at_end)
                        begin
                            res_valid     = 1'b1;
                            res.kind      = KIND_EMPTY;
                            res.last      = 1'b1;
                            res.truncated = (len_next != '0);
                            phase_next    = PH_DONE;
                        end
                        else
                        begin
                            left_next  = LEFT_W'(len_next);
                            phase_next = PH_VALUE;
                        end
                    end
                    else if (id_next == ID_END || at_end)
                    begin
                        res_valid  = 1'b1;
                        res.last   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        left_next = padded;
                        if (padded != '0)
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            hbc_reg   <= 2'd0;
            id_reg    <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            hbc_reg   <= hbc_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
        end
    end

endmodule
